FILE: src/wphg_pkg.sv
`timescale 1ns / 1ps
package wphg_pkg;

	localparam int HASH_W = 64;
	localparam int CP_W = 21;
	localparam int HALF_W = HASH_W / 2;
	localparam int KIND_W = 2;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [CP_W-1:0] CP_YO = 21'd1105;
	localparam logic [CP_W-1:0] CP_E = 21'd1077;
	localparam logic [CP_W-1:0] CP_NBSP = 21'd160;
	localparam logic [CP_W-1:0] CP_PLUS = 21'd43;

	localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FOLDED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TERM = 2'd2;

	typedef struct packed {
		logic [HASH_W-1:0] hash_value;
		logic [KIND_W-1:0] hash_kind;
		logic              last_of_item;
	} res_t;

endpackage

FILE: src/wphg_if.sv
`timescale 1ns / 1ps
interface wphg_item_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [wphg_pkg::CP_W-1:0] code_point;

	modport source (output valid, output mode, output code_point, input ready);
	modport sink (input valid, input mode, input code_point, output ready);
endinterface

interface wphg_result_if;
	logic                        valid;
	logic                        ready;
	logic [wphg_pkg::HASH_W-1:0] hash_value;
	logic [wphg_pkg::KIND_W-1:0] hash_kind;
	logic                        last_of_item;

	modport source (output valid, output hash_value, output hash_kind, output last_of_item,
		input ready);
	modport sink (input valid, input hash_value, input hash_kind, input last_of_item,
		output ready);
endinterface

FILE: src/wphg_pprod.sv
`timescale 1ns / 1ps
// low 64 bits of hash * mult, split into registered 32x32 partial products
module wphg_pprod (
	input  logic                        clk,
	input  logic                        en,
	input  logic [wphg_pkg::HASH_W-1:0] hash,
	input  logic [wphg_pkg::HASH_W-1:0] mult,
	output logic [wphg_pkg::HASH_W-1:0] ll_s2,
	output logic [wphg_pkg::HALF_W-1:0] cross_s2
);
	localparam int H = wphg_pkg::HALF_W;
	localparam int W = wphg_pkg::HASH_W;

	logic [W-1:0] ll;
	logic [H-1:0] cross_a;
	logic [H-1:0] cross_b;

	assign ll = {{H{1'b0}}, hash[H-1:0]} * {{H{1'b0}}, mult[H-1:0]};
	assign cross_a = hash[W-1:H] * mult[H-1:0];
	assign cross_b = hash[H-1:0] * mult[W-1:H];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s2 <= ll;
			cross_s2 <= cross_a + cross_b;
		end
	end
endmodule

FILE: src/wphg_outq.sv
`timescale 1ns / 1ps
// result queue, takes up to two requests per cycle
module wphg_outq #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           wr_n,
	input  wphg_pkg::res_t       wr_a,
	input  wphg_pkg::res_t       wr_b,
	output logic                 room2,
	wphg_result_if.source        result
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	wphg_pkg::res_t   ent_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic [PW-1:0]    wr_ptr1;
	logic [PW-1:0]    wr_ptr2;
	logic [PW-1:0]    rd_ptr1;
	logic             pop;

	assign wr_ptr1 = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign wr_ptr2 = (wr_ptr1 == PW'(DEPTH - 1)) ? '0 : wr_ptr1 + 1'b1;
	assign rd_ptr1 = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign pop = result.valid && result.ready;
	assign room2 = cnt_q <= CW'(DEPTH - 2);

	assign result.valid = cnt_q != '0;
	assign result.hash_value = ent_q[rd_ptr_q].hash_value;
	assign result.hash_kind = ent_q[rd_ptr_q].hash_kind;
	assign result.last_of_item = ent_q[rd_ptr_q].last_of_item;

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			ent_q[wr_ptr_q] <= wr_a;
		end
		if (wr_n == 2'd2) begin
			ent_q[wr_ptr1] <= wr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (wr_n)
				2'd1: wr_ptr_q <= wr_ptr1;
				2'd2: wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= rd_ptr1;
			end
			cnt_q <= cnt_q + CW'(wr_n) - CW'(pop);
		end
	end
endmodule

FILE: src/word_prefix_hash_generator.sv
`timescale 1ns / 1ps
// channel   dir  fields
// item      in   mode, code_point
// result    out  hash_value, hash_kind, last_of_item
// cfg       in   cfg_wr_en, cfg_wr_data (hash_multiplier)
//
// Partial products are registered in the first stage, the final adds and the
// hash state update happen in the second stage; the next item's products need
// that updated state, so a new item waits in the first stage until then.
// Results go through a four-entry queue; a stalled result side stops
// the second stage once fewer than two entries are free.
// Reset clears the hashes, the no-break-space flag and sets the multiplier to 1.
module word_prefix_hash_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [wphg_pkg::HASH_W-1:0] cfg_wr_data,
	wphg_item_if.sink                   item,
	wphg_result_if.source               result
);
	localparam int W = wphg_pkg::HASH_W;
	localparam int H = wphg_pkg::HALF_W;
	localparam int CPW = wphg_pkg::CP_W;

	logic [W-1:0]   mult_q;
	logic [W-1:0]   plain_q;
	logic [W-1:0]   fold_q;
	logic           nbsp_q;

	logic           v_s1;
	logic           mode_s1;
	logic [CPW-1:0] cp_s1;
	logic           v_s2;
	logic           mode_s2;
	logic [CPW-1:0] cp_s2;
	logic [CPW-1:0] fcp_s2;

	logic [W-1:0]   pl_ll_s2;
	logic [H-1:0]   pl_x_s2;
	logic [W-1:0]   fo_ll_s2;
	logic [H-1:0]   fo_x_s2;

	logic           accept;
	logic           adv1;
	logic           adv2;
	logic           room2;

	logic [W-1:0]   plain_sum;
	logic [W-1:0]   fold_sum;
	logic           nb;
	logic           e0;
	logic           e1;
	logic [1:0]     wr_n;
	wphg_pkg::res_t wr_a;
	wphg_pkg::res_t wr_b;

	assign item.ready = !v_s1 || !v_s2;
	assign accept = item.valid && item.ready;
	assign adv1 = v_s1 && !v_s2;
	assign adv2 = v_s2 && room2;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= item.mode;
			cp_s1 <= item.code_point;
		end
		if (adv1) begin
			mode_s2 <= mode_s1;
			cp_s2 <= cp_s1;
			fcp_s2 <= (cp_s1 == wphg_pkg::CP_YO) ? wphg_pkg::CP_E : cp_s1;
		end
	end

	wphg_pprod u_pp_plain (
		.clk      (clk),
		.en       (adv1),
		.hash     (plain_q),
		.mult     (mult_q),
		.ll_s2    (pl_ll_s2),
		.cross_s2 (pl_x_s2)
	);

	wphg_pprod u_pp_fold (
		.clk      (clk),
		.en       (adv1),
		.hash     (fold_q),
		.mult     (mult_q),
		.ll_s2    (fo_ll_s2),
		.cross_s2 (fo_x_s2)
	);

	assign plain_sum = pl_ll_s2 + {pl_x_s2, {H{1'b0}}} + {{(W-CPW){1'b0}}, cp_s2};
	assign fold_sum = fo_ll_s2 + {fo_x_s2, {H{1'b0}}} + {{(W-CPW){1'b0}}, fcp_s2};
	assign nb = nbsp_q || (plain_q == '0 && cp_s2 == wphg_pkg::CP_NBSP);
	assign e0 = plain_sum != '0;
	assign e1 = fold_sum != plain_sum && fold_sum != '0;

	always_comb begin
		wr_n = 2'd0;
		wr_a = '{hash_value: plain_sum, hash_kind: wphg_pkg::KIND_PLAIN, last_of_item: 1'b1};
		wr_b = '{hash_value: fold_sum, hash_kind: wphg_pkg::KIND_FOLDED, last_of_item: 1'b1};
		if (adv2) begin
			priority if (mode_s2) begin
				wr_n = 2'd1;
				wr_a.hash_value = '0;
				wr_a.hash_kind = wphg_pkg::KIND_TERM;
			end else if (cp_s2 == wphg_pkg::CP_PLUS) begin
				wr_a.hash_value = plain_q;
				wr_n = nb ? 2'd1 : 2'd0;
			end else if (!nb) begin
				unique case ({e0, e1})
					2'b11: begin
						wr_n = 2'd2;
						wr_a.last_of_item = 1'b0;
					end
					2'b10: wr_n = 2'd1;
					2'b01: begin
						wr_n = 2'd1;
						wr_a = wr_b;
					end
					default: wr_n = 2'd0;
				endcase
			end
		end
	end

	wphg_outq #(
		.DEPTH (wphg_pkg::OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_n   (wr_n),
		.wr_a   (wr_a),
		.wr_b   (wr_b),
		.room2  (room2),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			mult_q <= {{(W-1){1'b0}}, 1'b1};
			plain_q <= '0;
			fold_q <= '0;
			nbsp_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (cfg_wr_en) begin
				mult_q <= cfg_wr_data;
			end
			if (adv2) begin
				if (mode_s2 || cp_s2 == wphg_pkg::CP_PLUS) begin
					plain_q <= '0;
					fold_q <= '0;
					nbsp_q <= 1'b0;
				end else begin
					plain_q <= plain_sum;
					fold_q <= fold_sum;
					nbsp_q <= nb;
				end
			end
		end
	end
endmodule

FILE: src/wphg_checker.sv
`timescale 1ns / 1ps
module wphg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [wphg_pkg::HASH_W-1:0] res_hash_value,
	input logic [wphg_pkg::KIND_W-1:0] res_hash_kind,
	input logic                        res_last
);
	logic item_acc;

	assign item_acc = item_valid && item_ready;

	// state feedback: two requests back to back block the third
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc ##1 item_acc |=> !item_ready)
		else $error("third request taken before hash state update");

	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_hash_kind == wphg_pkg::KIND_TERM |-> res_last && res_hash_value == '0)
		else $error("bad terminator");

	a_fold_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_hash_kind == wphg_pkg::KIND_FOLDED |-> res_last)
		else $error("folded hash not last of request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_hash_value)
			&& $stable(res_hash_kind))
		else $error("stalled result changed");
endmodule

bind word_prefix_hash_generator wphg_checker u_wphg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_hash_value (result.hash_value),
	.res_hash_kind  (result.hash_kind),
	.res_last       (result.last_of_item)
);
